// ===== design/kesenc_pkg.sv =====
// Shared types, constants and the key classification function of the escape sequence encoder.
package kesenc_pkg;

  // Longest sequence in bytes, and the default depth of the queue between front and back.
  localparam int MaxSeqLen   = 7;
  localparam int QueueDepth  = 2;

  // Configuration register indexes.
  localparam logic [0:0] CFG_CURSOR_MODE = 1'd0;
  localparam logic [0:0] CFG_KEYPAD_MODE = 1'd1;

  // Modifier bits.
  localparam int ModShift = 0;
  localparam int ModAlt   = 1;
  localparam int ModCtrl  = 2;

  // Byte values.
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  // Key codes.
  localparam logic [7:0] KEY_BACK       = 8'd4;
  localparam logic [7:0] KEY_UP         = 8'd19;
  localparam logic [7:0] KEY_DOWN       = 8'd20;
  localparam logic [7:0] KEY_LEFT       = 8'd21;
  localparam logic [7:0] KEY_RIGHT      = 8'd22;
  localparam logic [7:0] KEY_CENTER     = 8'd23;
  localparam logic [7:0] KEY_TAB        = 8'd61;
  localparam logic [7:0] KEY_SPACE      = 8'd62;
  localparam logic [7:0] KEY_ENTER      = 8'd66;
  localparam logic [7:0] KEY_DEL        = 8'd67;
  localparam logic [7:0] KEY_PAGE_UP    = 8'd92;
  localparam logic [7:0] KEY_PAGE_DOWN  = 8'd93;
  localparam logic [7:0] KEY_ESCAPE     = 8'd111;
  localparam logic [7:0] KEY_FWD_DEL    = 8'd112;
  localparam logic [7:0] KEY_SYSRQ      = 8'd120;
  localparam logic [7:0] KEY_BREAK      = 8'd121;
  localparam logic [7:0] KEY_HOME       = 8'd122;
  localparam logic [7:0] KEY_END        = 8'd123;
  localparam logic [7:0] KEY_INSERT     = 8'd124;
  localparam logic [7:0] KEY_F1         = 8'd131;
  localparam logic [7:0] KEY_F2         = 8'd132;
  localparam logic [7:0] KEY_F3         = 8'd133;
  localparam logic [7:0] KEY_F4         = 8'd134;
  localparam logic [7:0] KEY_F5         = 8'd135;
  localparam logic [7:0] KEY_F6         = 8'd136;
  localparam logic [7:0] KEY_F7         = 8'd137;
  localparam logic [7:0] KEY_F8         = 8'd138;
  localparam logic [7:0] KEY_F9         = 8'd139;
  localparam logic [7:0] KEY_F10        = 8'd140;
  localparam logic [7:0] KEY_F11        = 8'd141;
  localparam logic [7:0] KEY_F12        = 8'd142;
  localparam logic [7:0] KEY_NUM_LOCK   = 8'd143;
  localparam logic [7:0] KEY_NUMPAD_0   = 8'd144;
  localparam logic [7:0] KEY_NUMPAD_1   = 8'd145;
  localparam logic [7:0] KEY_NUMPAD_2   = 8'd146;
  localparam logic [7:0] KEY_NUMPAD_3   = 8'd147;
  localparam logic [7:0] KEY_NUMPAD_4   = 8'd148;
  localparam logic [7:0] KEY_NUMPAD_5   = 8'd149;
  localparam logic [7:0] KEY_NUMPAD_6   = 8'd150;
  localparam logic [7:0] KEY_NUMPAD_7   = 8'd151;
  localparam logic [7:0] KEY_NUMPAD_8   = 8'd152;
  localparam logic [7:0] KEY_NUMPAD_9   = 8'd153;
  localparam logic [7:0] KEY_NUMPAD_DIV = 8'd154;
  localparam logic [7:0] KEY_NUMPAD_MUL = 8'd155;
  localparam logic [7:0] KEY_NUMPAD_SUB = 8'd156;
  localparam logic [7:0] KEY_NUMPAD_ADD = 8'd157;
  localparam logic [7:0] KEY_NUMPAD_DOT = 8'd158;
  localparam logic [7:0] KEY_NUMPAD_CMA = 8'd159;
  localparam logic [7:0] KEY_NUMPAD_ENT = 8'd160;
  localparam logic [7:0] KEY_NUMPAD_EQ  = 8'd161;

  // One encoded sequence: byte 0 goes out first.
  typedef struct packed {
    logic [MaxSeqLen-1:0][7:0] b;
    logic [2:0]                len;
  } seq_t;

  // A sequence request moving between the parts of the block.
  typedef struct packed {
    logic valid;
    seq_t seq;
  } seq_req_t;

  localparam seq_t SEQ_EMPTY = '{b: '0, len: 3'd0};

  // Append one byte when room is left.
  function automatic seq_t put(seq_t s, logic [7:0] c);
    seq_t r;
    r = s;
    if (s.len < 3'(MaxSeqLen)) begin
      r.b[s.len] = c;
      r.len      = s.len + 3'd1;
    end
    return r;
  endfunction

  // Prefix of up to four bytes (first byte in the top bits), optional ";N", final byte.
  function automatic seq_t with_mod(logic [31:0] pre, logic [2:0] plen, logic [2:0] mods,
                                    logic [7:0] fin);
    seq_t r;
    r = SEQ_EMPTY;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < plen) r = put(r, pre[31-8*i -: 8]);
    end
    if (mods != 3'd0) begin
      r = put(r, CH_SEMI);
      r = put(r, CH_ONE + {5'd0, mods});
    end
    r = put(r, fin);
    return r;
  endfunction

  // Cursor-style key: modified form always uses the CSI 1 prefix.
  function automatic seq_t cursor_key(logic [2:0] mods, logic app, logic [7:0] fin);
    seq_t r;
    if (mods != 3'd0) r = with_mod({CH_ESC, "[1", 8'h00}, 3'd3, mods, fin);
    else r = with_mod({CH_ESC, (app ? "O" : "["), 16'h0000}, 3'd2, 3'd0, fin);
    return r;
  endfunction

  // Keypad key: SS3 sequence in application keypad mode, plain character otherwise.
  function automatic seq_t keypad_key(logic [2:0] mods, logic kapp, logic [7:0] app_ch,
                                      logic [7:0] plain);
    seq_t r;
    if (kapp) r = with_mod({CH_ESC, "O", 16'h0000}, 3'd2, mods, app_ch);
    else r = put(SEQ_EMPTY, plain);
    return r;
  endfunction

  // Tilde-terminated key with a two-digit or one-digit parameter.
  function automatic seq_t tilde2(logic [15:0] num, logic [2:0] mods);
    return with_mod({CH_ESC, "[", num}, 3'd4, mods, CH_TILDE);
  endfunction

  function automatic seq_t tilde1(logic [7:0] num, logic [2:0] mods);
    return with_mod({CH_ESC, "[", num, 8'h00}, 3'd3, mods, CH_TILDE);
  endfunction

  // Full classification of one key event.
  function automatic seq_t encode(logic [7:0] key, logic [2:0] mods, logic nl, logic capp,
                                  logic kapp);
    seq_t r;
    r = SEQ_EMPTY;
    case (key) inside
      KEY_CENTER:    r = put(SEQ_EMPTY, CH_CR);
      KEY_UP:        r = cursor_key(mods, capp, "A");
      KEY_DOWN:      r = cursor_key(mods, capp, "B");
      KEY_RIGHT:     r = cursor_key(mods, capp, "C");
      KEY_LEFT:      r = cursor_key(mods, capp, "D");
      KEY_HOME:      r = cursor_key(mods, capp, "H");
      KEY_END:       r = cursor_key(mods, capp, "F");
      KEY_F1:        r = cursor_key(mods, 1'b1, "P");
      KEY_F2:        r = cursor_key(mods, 1'b1, "Q");
      KEY_F3:        r = cursor_key(mods, 1'b1, "R");
      KEY_F4:        r = cursor_key(mods, 1'b1, "S");
      KEY_F5:        r = tilde2("15", mods);
      KEY_F6:        r = tilde2("17", mods);
      KEY_F7:        r = tilde2("18", mods);
      KEY_F8:        r = tilde2("19", mods);
      KEY_F9:        r = tilde2("20", mods);
      KEY_F10:       r = tilde2("21", mods);
      KEY_F11:       r = tilde2("23", mods);
      KEY_F12:       r = tilde2("24", mods);
      KEY_SYSRQ:     r = tilde2("32", 3'd0);
      KEY_BREAK:     r = tilde2("34", 3'd0);
      KEY_ESCAPE, KEY_BACK: r = put(SEQ_EMPTY, CH_ESC);
      KEY_INSERT:    r = tilde1("2", mods);
      KEY_FWD_DEL:   r = tilde1("3", mods);
      KEY_PAGE_UP:   r = tilde1("5", mods);
      KEY_PAGE_DOWN: r = tilde1("6", mods);
      KEY_DEL: begin
        if (mods[ModAlt]) r = put(r, CH_ESC);
        r = put(r, mods[ModCtrl] ? CH_BS : CH_DEL);
      end
      KEY_NUM_LOCK: begin
        if (kapp) r = with_mod({CH_ESC, "O", 16'h0000}, 3'd2, 3'd0, "P");
      end
      KEY_SPACE: begin
        if (mods[ModCtrl]) r = put(SEQ_EMPTY, CH_NUL);
      end
      KEY_TAB: begin
        // Back-tab sends the full CSI Z sequence.
        if (mods[ModShift]) r = with_mod({CH_ESC, "[", 16'h0000}, 3'd2, 3'd0, "Z");
        else r = put(SEQ_EMPTY, CH_TAB);
      end
      KEY_ENTER: begin
        if (mods[ModAlt]) r = put(r, CH_ESC);
        r = put(r, CH_CR);
      end
      KEY_NUMPAD_ENT: r = keypad_key(mods, kapp, "M", CH_LF);
      KEY_NUMPAD_MUL: r = keypad_key(mods, kapp, "j", "*");
      KEY_NUMPAD_ADD: r = keypad_key(mods, kapp, "k", "+");
      KEY_NUMPAD_CMA: r = put(SEQ_EMPTY, ",");
      KEY_NUMPAD_DOT: begin
        if (nl) begin
          if (kapp) r = with_mod({CH_ESC, "O", 16'h0000}, 3'd2, 3'd0, "n");
          else r = put(SEQ_EMPTY, ".");
        end else begin
          r = tilde1("3", mods);
        end
      end
      KEY_NUMPAD_SUB: r = keypad_key(mods, kapp, "m", "-");
      KEY_NUMPAD_DIV: r = keypad_key(mods, kapp, "o", "/");
      KEY_NUMPAD_0: r = nl ? keypad_key(mods, kapp, "p", "0") : tilde1("2", mods);
      KEY_NUMPAD_1: r = nl ? keypad_key(mods, kapp, "q", "1") : cursor_key(mods, capp, "F");
      KEY_NUMPAD_2: r = nl ? keypad_key(mods, kapp, "r", "2") : cursor_key(mods, capp, "B");
      KEY_NUMPAD_3: r = nl ? keypad_key(mods, kapp, "s", "3") : tilde1("6", 3'd0);
      KEY_NUMPAD_4: r = nl ? keypad_key(mods, kapp, "t", "4") : cursor_key(mods, capp, "D");
      KEY_NUMPAD_5: r = keypad_key(mods, kapp, "u", "5");
      KEY_NUMPAD_6: r = nl ? keypad_key(mods, kapp, "v", "6") : cursor_key(mods, capp, "C");
      KEY_NUMPAD_7: r = nl ? keypad_key(mods, kapp, "w", "7") : cursor_key(mods, capp, "H");
      KEY_NUMPAD_8: r = nl ? keypad_key(mods, kapp, "x", "8") : cursor_key(mods, capp, "A");
      KEY_NUMPAD_9: r = nl ? keypad_key(mods, kapp, "y", "9") : tilde1("5", 3'd0);
      KEY_NUMPAD_EQ: r = keypad_key(mods, kapp, "X", "=");
      default: r = SEQ_EMPTY;
    endcase
    return r;
  endfunction

endpackage

// ===== design/kesenc_if.sv =====
// Handshake interfaces for the key event channel and the byte channel.
interface kesenc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_id;
  logic [2:0] modifiers;
  logic       num_lock;

  modport source (output valid, key_id, modifiers, num_lock, input ready);
  modport sink   (input valid, key_id, modifiers, num_lock, output ready);
endinterface

interface kesenc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

// ===== design/kesenc_front.sv =====
// Front part: accepts key events, classifies them and registers the encoded sequence.
module kesenc_front (
  input  logic                clk,
  input  logic                rst_n,
  kesenc_in_if.sink           in_ch,
  input  logic                cursor_ss3,
  input  logic                keypad_ss3,
  output kesenc_pkg::seq_req_t req_o,
  input  logic                req_ready
);

  logic              valid_r, valid_nxt;
  kesenc_pkg::seq_t  seq_r, seq_nxt, enc;
  logic              accept;

  // The stage takes a new request whenever it is empty or its request moves on.
  assign in_ch.ready = !valid_r || req_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Classify the key event against the current modes.
  always_comb begin
    enc = kesenc_pkg::encode(in_ch.key_id, in_ch.modifiers, in_ch.num_lock,
                             cursor_ss3, keypad_ss3);
  end

  // Keys that map to nothing never enter the queue.
  always_comb begin
    valid_nxt = valid_r;
    seq_nxt   = seq_r;
    if (accept) begin
      valid_nxt = (enc.len != 3'd0);
      seq_nxt   = enc;
    end else if (req_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r <= seq_nxt;
  end

  assign req_o.valid = valid_r;
  assign req_o.seq   = seq_r;

endmodule

// ===== design/kesenc_queue.sv =====
// Short queue of encoded sequences between the front and the back part.
module kesenc_queue #(
  parameter int DEPTH = kesenc_pkg::QueueDepth
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kesenc_pkg::seq_req_t push_i,
  output logic                 push_ready,
  output kesenc_pkg::seq_req_t head_o,
  input  logic                 pop
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  kesenc_pkg::seq_t  mem_r [DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != CntW'(DEPTH));
  assign do_push    = push_i.valid && push_ready;
  assign do_pop     = pop && (count_r != '0);

  // Pointer and fill count update, with wrap at the last entry.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) count_nxt = count_r + CntW'(1);
    else if (do_pop && !do_push) count_nxt = count_r - CntW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_i.seq;
  end

  assign head_o.valid = (count_r != '0);
  assign head_o.seq   = mem_r[rd_ptr_r];

endmodule

// ===== design/kesenc_back.sv =====
// Back part: sends a queued sequence one byte per cycle through an output register, holding while the sink stalls.
module kesenc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kesenc_pkg::seq_req_t head_i,
  output logic                 pop,
  kesenc_out_if.source         out_ch
);

  localparam int SeqW = kesenc_pkg::MaxSeqLen * 8;

  logic [SeqW-1:0] rest_r, rest_nxt;
  logic [2:0]      left_r, left_nxt;
  logic            ov_r, ov_nxt;
  logic [7:0]      byte_r, byte_nxt;
  logic            last_r, last_nxt;
  logic            advance;

  // The output register may take a new byte when empty or when its byte is taken.
  assign advance = !ov_r || out_ch.ready;
  assign pop     = advance && (left_r == 3'd0) && head_i.valid;

  always_comb begin
    rest_nxt = rest_r;
    left_nxt = left_r;
    ov_nxt   = ov_r;
    byte_nxt = byte_r;
    last_nxt = last_r;
    if (advance) begin
      if (left_r != 3'd0) begin
        // Continue the sequence in progress.
        ov_nxt   = 1'b1;
        byte_nxt = rest_r[7:0];
        last_nxt = (left_r == 3'd1);
        rest_nxt = rest_r >> 8;
        left_nxt = left_r - 3'd1;
      end else if (head_i.valid) begin
        // Start the next queued sequence with its first byte.
        ov_nxt   = 1'b1;
        byte_nxt = head_i.seq.b[0];
        last_nxt = (head_i.seq.len == 3'd1);
        rest_nxt = head_i.seq.b >> 8;
        left_nxt = head_i.seq.len - 3'd1;
      end else begin
        ov_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      left_r <= 3'd0;
    end else begin
      ov_r   <= ov_nxt;
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rest_r <= rest_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign out_ch.valid    = ov_r;
  assign out_ch.out_byte = byte_r;
  assign out_ch.last     = last_r;

endmodule

// ===== design/key_to_escape_sequence_encoder_core.sv =====
// Top level of the key event to terminal escape sequence encoder.
//
//   Port group | Direction | Carries
//   in_ch      | sink      | key_id, modifiers, num_lock
//   out_ch     | source    | out_byte, last
//   cfg_*      | write     | cursor and keypad mode bits
//
// A key event is classified and registered in the front stage, and its one to seven bytes leave
// one per cycle while the byte sink takes them; the output byte register sets that pace.
// A key that maps to nothing is accepted by the front stage and sends nothing.
// Reset is synchronous and clears both mode bits and all valid state.
// The queue lets the front accept events while the back is stalled by the byte sink.
module key_to_escape_sequence_encoder_core #(
  parameter int QUEUE_DEPTH = kesenc_pkg::QueueDepth
) (
  input  logic         clk,
  input  logic         rst_n,
  kesenc_in_if.sink    in_ch,
  kesenc_out_if.source out_ch,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_idx,
  input  logic [0:0]   cfg_wdata
);

  logic                 cursor_ss3_r, keypad_ss3_r;
  kesenc_pkg::seq_req_t front_req, head;
  logic                 front_ready, pop;

  // Mode registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_ss3_r <= 1'b0;
      keypad_ss3_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_idx == kesenc_pkg::CFG_CURSOR_MODE) cursor_ss3_r <= cfg_wdata[0];
      if (cfg_idx == kesenc_pkg::CFG_KEYPAD_MODE) keypad_ss3_r <= cfg_wdata[0];
    end
  end

  kesenc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cursor_ss3 (cursor_ss3_r),
    .keypad_ss3 (keypad_ss3_r),
    .req_o      (front_req),
    .req_ready  (front_ready)
  );

  kesenc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (front_req),
    .push_ready (front_ready),
    .head_o     (head),
    .pop        (pop)
  );

  kesenc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head_i (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // The back part only pops a queue that holds a sequence.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("queue popped while empty");

  // Every queued sequence carries at least one byte.
  a_queued_len: assert property (@(posedge clk) disable iff (!rst_n)
    head.valid |-> (head.seq.len != 3'd0))
    else $error("empty sequence in queue");

  // Nothing is offered on the byte channel right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("byte offered after reset");

endmodule
